// ----- hdl/sprite_row_budget_admission_top_macros.svh -----
// Assertion macros shared by the sprite row budget admission block.
`ifndef SPRITE_ROW_BUDGET_ADMISSION_TOP_MACROS_SVH
`define SPRITE_ROW_BUDGET_ADMISSION_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/srba_pkg.sv -----
// Package with the types, codes and defaults of the sprite row budget admission block.
`timescale 1ns / 1ps

package srba_pkg;

   localparam int ROW_BANDS_DEF     = 18;
   localparam int SCREEN_WIDTH_DEF  = 160;
   localparam int SCREEN_HEIGHT_DEF = 144;

   localparam logic [3:0] ROW_LIMIT_RST  = 4'd10;
   localparam logic [5:0] SLOT_LIMIT_RST = 6'd40;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_LIMIT = 2'd1;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_OBJECT = 2'd1;
   localparam logic [1:0] CMD_SHOT   = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_POS    = 7'b0000010,
      ST_BOUND  = 7'b0000100,
      ST_CHECK  = 7'b0001000,
      ST_COMMIT = 7'b0010000,
      ST_SLOT   = 7'b0100000,
      ST_RESP   = 7'b1000000
   } state_type;

endpackage

// ----- hdl/sprite_row_budget_admission_top.sv -----
// Sprite row budget admission: a one-item-at-a-time sequencer with a shared band adder.
`timescale 1ns / 1ps
`include "sprite_row_budget_admission_top_macros.svh"

// Admits whole sprite objects and shots into a frame against a per-row-band column budget
// and a frame slot budget. Each request transaction gives exactly one response
// transaction. A clear or unused command goes from acceptance straight to the
// response state. A general object or a shot passes a position stage and a
// bounds stage; then one band adder and comparator walks the bands it touches
// once to check them and once more to commit them. A rejection found early
// ends sooner. A new request is taken as soon as the sequencer is back in idle,
// even while the previous response waits.
module sprite_row_budget_admission_top #(
   parameter int ROW_BANDS     = srba_pkg::ROW_BANDS_DEF,
   parameter int SCREEN_WIDTH  = srba_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = srba_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [srba_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [srba_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_command,
   input  logic signed [15:0]                 req_pos_x,
   input  logic signed [15:0]                 req_pos_y,
   input  logic [7:0]                         req_origin_x,
   input  logic [7:0]                         req_origin_y,
   input  logic [7:0]                         req_object_width,
   input  logic [7:0]                         req_object_height,
   input  logic [5:0]                         req_object_tiles,
   input  logic [7:0]                         req_shot_y,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_admitted,
   output logic [5:0]                         rsp_slots_used
);

   localparam int BW = (ROW_BANDS > 1) ? $clog2(ROW_BANDS) : 1;
   localparam logic signed [13:0] SW_S   = 14'(SCREEN_WIDTH);
   localparam logic signed [13:0] SH_S   = 14'(SCREEN_HEIGHT);
   localparam logic signed [13:0] ZERO_S = 14'sd0;
   localparam logic [5:0] BANDS_W   = 6'(ROW_BANDS);
   localparam logic [5:0] LAST_BAND = 6'(ROW_BANDS - 1);

   srba_pkg::state_type state_ff, state_in;

   logic [3:0] row_limit_ff, row_limit_in;
   logic [5:0] slot_limit_ff, slot_limit_in;
   logic [3:0] row_counts_ff [ROW_BANDS];
   logic [3:0] row_counts_in [ROW_BANDS];
   logic [5:0] slot_count_ff, slot_count_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_admitted_ff, rsp_admitted_in;
   logic [5:0] rsp_slots_used_ff, rsp_slots_used_in;

   // Captured request fields.
   logic [1:0]         cmd_ff, cmd_in;
   logic signed [15:0] pos_x_ff, pos_x_in;
   logic signed [15:0] pos_y_ff, pos_y_in;
   logic [7:0]         origin_x_ff, origin_x_in;
   logic [7:0]         origin_y_ff, origin_y_in;
   logic [7:0]         width_ff, width_in;
   logic [7:0]         height_ff, height_in;
   logic [5:0]         tiles_ff, tiles_in;
   logic [7:0]         shot_y_ff, shot_y_in;

   // Working registers of the sequencer.
   logic signed [13:0] left_ff, left_in;
   logic signed [13:0] top_ff, top_in;
   logic [4:0]         addend_ff, addend_in;
   logic [5:0]         tiles_add_ff, tiles_add_in;
   logic [5:0]         hi_ff, hi_in;
   logic [5:0]         idx_ff, idx_in;
   logic               res_admitted_ff, res_admitted_in;

   // Position stage.
   logic               qx_fix, qy_fix;
   logic signed [11:0] qx, qy;

   // Bounds stage.
   logic signed [13:0] right_edge, bottom_edge;
   logic [8:0]         h_sum, h_round;
   logic [7:0]         top_c, bottom_c;
   logic [8:0]         hi_sum;
   logic [5:0]         obj_hi_raw, obj_hi, obj_lo;
   logic               obj_reject;
   logic [7:0]         y_m1, y_m16;
   logic [5:0]         shot_first, shot_last_raw, shot_last, shot_hi;
   logic               shot_reject;

   // Shared units.
   logic [6:0] slot_sum;
   logic       slot_fail;
   logic [3:0] band_count;
   logic [5:0] band_sum;
   logic       band_fail;
   logic       band_done;
   logic       req_fire;

   // Conditions watched by the assertions.
   logic       commit_step;
   logic       slot_step;
   logic       clear_fire;

   assign req_ready      = (state_ff == srba_pkg::ST_IDLE);
   assign req_fire       = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_admitted   = rsp_admitted_ff;
   assign rsp_slots_used = rsp_slots_used_ff;

   // Shared slot adder and band adder.
   assign slot_sum   = {1'b0, slot_count_ff} + {1'b0, tiles_add_ff};
   assign slot_fail  = slot_sum > {1'b0, slot_limit_ff};
   assign band_count = row_counts_ff[idx_ff[BW-1:0]];
   assign band_sum   = {2'b00, band_count} + {1'b0, addend_ff};
   assign band_fail  = band_sum > {2'b00, row_limit_ff};
   assign band_done  = idx_ff >= hi_ff;

   // Q4 to pixels, truncating toward zero.
   always_comb begin
      qx_fix = pos_x_ff[15] & (|pos_x_ff[3:0]);
      qy_fix = pos_y_ff[15] & (|pos_y_ff[3:0]);
      qx     = $signed(pos_x_ff[15:4]) + $signed({11'b0, qx_fix});
      qy     = $signed(pos_y_ff[15:4]) + $signed({11'b0, qy_fix});
   end

   // Object bounds, clipping and band range.
   always_comb begin
      right_edge  = left_ff + $signed({6'b0, width_ff});
      h_sum       = {1'b0, height_ff} + 9'd15;
      h_round     = {h_sum[8:4], 4'b0000};
      bottom_edge = top_ff + $signed({5'b0, h_round});
      obj_reject  = (left_ff >= SW_S) || (right_edge <= ZERO_S) ||
                    (bottom_edge <= ZERO_S) || (top_ff >= SH_S) || slot_fail;
      top_c       = top_ff[13] ? 8'd0 : top_ff[7:0];
      bottom_c    = (bottom_edge > SH_S) ? 8'(SCREEN_HEIGHT) : bottom_edge[7:0];
      hi_sum      = {1'b0, bottom_c} + 9'd7;
      obj_hi_raw  = hi_sum[8:3];
      obj_hi      = (obj_hi_raw > BANDS_W) ? BANDS_W : obj_hi_raw;
      obj_lo      = {1'b0, top_c[7:3]};
   end

   // Shot band range. An empty range is left with first beyond last.
   always_comb begin
      y_m1          = shot_y_ff - 8'd1;
      y_m16         = shot_y_ff - 8'd16;
      shot_first    = (shot_y_ff < 8'd16) ? 6'd0 : {1'b0, y_m16[7:3]};
      shot_last_raw = {1'b0, y_m1[7:3]};
      shot_last     = (shot_last_raw > LAST_BAND) ? LAST_BAND : shot_last_raw;
      shot_hi       = shot_last + 6'd1;
      shot_reject   = (shot_y_ff == 8'd0) || slot_fail;
   end

   // Sequencer.
   always_comb begin
      state_in          = state_ff;
      row_limit_in      = row_limit_ff;
      slot_limit_in     = slot_limit_ff;
      row_counts_in     = row_counts_ff;
      slot_count_in     = slot_count_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_admitted_in   = rsp_admitted_ff;
      rsp_slots_used_in = rsp_slots_used_ff;
      cmd_in            = cmd_ff;
      pos_x_in          = pos_x_ff;
      pos_y_in          = pos_y_ff;
      origin_x_in       = origin_x_ff;
      origin_y_in       = origin_y_ff;
      width_in          = width_ff;
      height_in         = height_ff;
      tiles_in          = tiles_ff;
      shot_y_in         = shot_y_ff;
      left_in           = left_ff;
      top_in            = top_ff;
      addend_in         = addend_ff;
      tiles_add_in      = tiles_add_ff;
      hi_in             = hi_ff;
      idx_in            = idx_ff;
      res_admitted_in   = res_admitted_ff;

      if (csr_write_en) begin
         case (csr_index)
            srba_pkg::CSR_ROW_LIMIT:  row_limit_in  = csr_wdata[3:0];
            srba_pkg::CSR_SLOT_LIMIT: slot_limit_in = csr_wdata[5:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         srba_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_in          = req_command;
               pos_x_in        = req_pos_x;
               pos_y_in        = req_pos_y;
               origin_x_in     = req_origin_x;
               origin_y_in     = req_origin_y;
               width_in        = req_object_width;
               height_in       = req_object_height;
               tiles_in        = req_object_tiles;
               shot_y_in       = req_shot_y;
               res_admitted_in = 1'b0;
               unique case (req_command)
                  srba_pkg::CMD_CLEAR: begin
                     for (int i = 0; i < ROW_BANDS; i++) begin
                        row_counts_in[i] = 4'd0;
                     end
                     slot_count_in = 6'd0;
                     state_in      = srba_pkg::ST_RESP;
                  end
                  srba_pkg::CMD_OBJECT: state_in = srba_pkg::ST_POS;
                  srba_pkg::CMD_SHOT:   state_in = srba_pkg::ST_POS;
                  srba_pkg::CMD_NONE:   state_in = srba_pkg::ST_RESP;
               endcase
            end
         end
         srba_pkg::ST_POS: begin
            left_in = {{2{qx[11]}}, qx} - {6'b0, origin_x_ff};
            top_in  = {{2{qy[11]}}, qy} - {6'b0, origin_y_ff};
            if (cmd_ff == srba_pkg::CMD_OBJECT) begin
               addend_in    = width_ff[7:3];
               tiles_add_in = tiles_ff;
            end else begin
               addend_in    = 5'd1;
               tiles_add_in = 6'd1;
            end
            state_in = srba_pkg::ST_BOUND;
         end
         srba_pkg::ST_BOUND: begin
            if (cmd_ff == srba_pkg::CMD_OBJECT) begin
               idx_in = obj_lo;
               hi_in  = obj_hi;
               state_in = obj_reject ? srba_pkg::ST_RESP : srba_pkg::ST_CHECK;
            end else begin
               idx_in = shot_first;
               hi_in  = shot_hi;
               state_in = shot_reject ? srba_pkg::ST_RESP : srba_pkg::ST_CHECK;
            end
         end
         srba_pkg::ST_CHECK: begin
            priority if (band_done) begin
               idx_in   = (cmd_ff == srba_pkg::CMD_OBJECT) ? obj_lo : shot_first;
               state_in = srba_pkg::ST_COMMIT;
            end else if (band_fail) begin
               state_in = srba_pkg::ST_RESP;
            end else begin
               idx_in = idx_ff + 6'd1;
            end
         end
         srba_pkg::ST_COMMIT: begin
            if (band_done) begin
               state_in = srba_pkg::ST_SLOT;
            end else begin
               row_counts_in[idx_ff[BW-1:0]] = band_sum[3:0];
               idx_in = idx_ff + 6'd1;
            end
         end
         srba_pkg::ST_SLOT: begin
            slot_count_in   = slot_sum[5:0];
            res_admitted_in = 1'b1;
            state_in        = srba_pkg::ST_RESP;
         end
         srba_pkg::ST_RESP: begin
            // The response register is free once the previous transaction has gone.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_admitted_in   = res_admitted_ff;
               rsp_slots_used_in = slot_count_ff;
               state_in          = srba_pkg::ST_IDLE;
            end
         end
         default: state_in = srba_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srba_pkg::ST_IDLE;
         row_limit_ff  <= srba_pkg::ROW_LIMIT_RST;
         slot_limit_ff <= srba_pkg::SLOT_LIMIT_RST;
         slot_count_ff <= 6'd0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < ROW_BANDS; i++) begin
            row_counts_ff[i] <= 4'd0;
         end
      end else begin
         state_ff      <= state_in;
         row_limit_ff  <= row_limit_in;
         slot_limit_ff <= slot_limit_in;
         slot_count_ff <= slot_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         row_counts_ff <= row_counts_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_admitted_ff   <= rsp_admitted_in;
      rsp_slots_used_ff <= rsp_slots_used_in;
      cmd_ff            <= cmd_in;
      pos_x_ff          <= pos_x_in;
      pos_y_ff          <= pos_y_in;
      origin_x_ff       <= origin_x_in;
      origin_y_ff       <= origin_y_in;
      width_ff          <= width_in;
      height_ff         <= height_in;
      tiles_ff          <= tiles_in;
      shot_y_ff         <= shot_y_in;
      left_ff           <= left_in;
      top_ff            <= top_in;
      addend_ff         <= addend_in;
      tiles_add_ff      <= tiles_add_in;
      hi_ff             <= hi_in;
      idx_ff            <= idx_in;
      res_admitted_ff   <= res_admitted_in;
   end

   assign commit_step = (state_ff == srba_pkg::ST_COMMIT) && !band_done;
   assign slot_step   = (state_ff == srba_pkg::ST_SLOT);
   assign clear_fire  = req_fire && (req_command == srba_pkg::CMD_CLEAR);

   // A band is only charged after the check pass has found room in it.
   `SRBA_ASSERT_SAME(a_commit_room, clock, reset, commit_step, !band_fail, "band over limit")
   // The slot total is only charged when the bounds stage found room for it.
   `SRBA_ASSERT_SAME(a_slot_room, clock, reset, slot_step, !slot_fail, "slot over limit")
   // A clear transaction empties the frame budget at once.
   `SRBA_ASSERT_NEXT(a_clear_empty, clock, reset, clear_fire, ~|slot_count_ff, "clear missed")

endmodule

// ----- tb/sprite_row_budget_admission_top_test.sv -----
// Self-checking testbench for the sprite row budget admission block.
`timescale 1ns / 1ps

module sprite_row_budget_admission_top_test;

   localparam int BANDS    = srba_pkg::ROW_BANDS_DEF;
   localparam int SCREEN_W = srba_pkg::SCREEN_WIDTH_DEF;
   localparam int SCREEN_H = srba_pkg::SCREEN_HEIGHT_DEF;

   // Indexes beyond the register list; writes to them must be ignored.
   localparam logic [srba_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [srba_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 275;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [1:0]        command;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [7:0]        origin_x;
      logic [7:0]        origin_y;
      logic [7:0]        object_width;
      logic [7:0]        object_height;
      logic [5:0]        object_tiles;
      logic [7:0]        shot_y;
   } request_type;

   typedef struct {
      logic       admitted;
      logic [5:0] slots_used;
   } outcome_type;

   class budget_scoreboard;
      logic [3:0] row_limit;
      logic [5:0] slot_limit;
      logic [3:0] band_columns [BANDS];
      logic [5:0] slots_taken;
      outcome_type expected_outcomes [$];
      int         mismatches;

      function new();
         row_limit  = srba_pkg::ROW_LIMIT_RST;
         slot_limit = srba_pkg::SLOT_LIMIT_RST;
         mismatches = 0;
         start_frame();
      endfunction

      function void start_frame();
         foreach (band_columns[b]) band_columns[b] = '0;
         slots_taken = '0;
      endfunction

      function void set_register(logic [srba_pkg::CSR_INDEX_W-1:0] index,
                                 logic [srba_pkg::CSR_DATA_W-1:0] data);
         case (index)
            srba_pkg::CSR_ROW_LIMIT:  row_limit = data[3:0];
            srba_pkg::CSR_SLOT_LIMIT: slot_limit = data;
            default: ;
         endcase
      endfunction

      function bit try_object(request_type r);
         int qx, qy, left, top, bottom, w, cols, lo, hi;
         qx = int'(r.pos_x) / 16;
         qy = int'(r.pos_y) / 16;
         w = int'(r.object_width);
         cols = w / 8;
         left = qx - int'(r.origin_x);
         top = qy - int'(r.origin_y);
         bottom = top + ((int'(r.object_height) + 15) & 'h1F0);
         if (left >= SCREEN_W || left + w <= 0 || bottom <= 0 || top >= SCREEN_H ||
             int'(slots_taken) + int'(r.object_tiles) > int'(slot_limit))
            return 1'b0;
         if (top < 0) top = 0;
         if (bottom > SCREEN_H) bottom = SCREEN_H;
         lo = top >> 3;
         hi = (bottom + 7) >> 3;
         if (hi > BANDS) hi = BANDS;
         for (int b = lo; b < hi; b++)
            if (int'(band_columns[b]) + cols > int'(row_limit)) return 1'b0;
         for (int b = lo; b < hi; b++)
            band_columns[b] = band_columns[b] + cols[3:0];
         slots_taken = slots_taken + r.object_tiles;
         return 1'b1;
      endfunction

      function bit try_shot(request_type r);
         int y, first, last;
         y = int'(r.shot_y);
         if (y == 0 || slots_taken >= slot_limit) return 1'b0;
         first = (y < 16) ? 0 : (y - 16) >> 3;
         last = (y - 1) >> 3;
         if (last > BANDS - 1) last = BANDS - 1;
         // When the first band lies past the last, no band is charged at all.
         for (int b = first; b <= last; b++)
            if (band_columns[b] >= row_limit) return 1'b0;
         for (int b = first; b <= last; b++)
            band_columns[b] = band_columns[b] + 4'd1;
         slots_taken = slots_taken + 6'd1;
         return 1'b1;
      endfunction

      function void note_request(request_type r);
         outcome_type o;
         o.admitted = 1'b0;
         case (r.command)
            srba_pkg::CMD_CLEAR:  start_frame();
            srba_pkg::CMD_OBJECT: o.admitted = try_object(r);
            srba_pkg::CMD_SHOT:   o.admitted = try_shot(r);
            default: ;
         endcase
         o.slots_used = slots_taken;
         expected_outcomes.push_back(o);
      endfunction

      function void check_response(logic admitted, logic [5:0] slots_used);
         outcome_type o;
         if (expected_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response: admitted=%0b slots_used=%0d",
                        admitted, slots_used);
         end else begin
            o = expected_outcomes.pop_front();
            if (admitted !== o.admitted || slots_used !== o.slots_used) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected admitted=%0b slots_used=%0d, got %0b and %0d",
                           o.admitted, o.slots_used, admitted, slots_used);
            end
         end
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_write_en = 1'b0;
   logic [srba_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [srba_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [1:0]                       req_command = '0;
   logic signed [15:0]               req_pos_x = '0;
   logic signed [15:0]               req_pos_y = '0;
   logic [7:0]                       req_origin_x = '0;
   logic [7:0]                       req_origin_y = '0;
   logic [7:0]                       req_object_width = '0;
   logic [7:0]                       req_object_height = '0;
   logic [5:0]                       req_object_tiles = '0;
   logic [7:0]                       req_shot_y = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_admitted;
   logic [5:0]                       rsp_slots_used;

   budget_scoreboard board;
   int req_idle_pct = 13;
   int rsp_idle_pct = 55;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   sprite_row_budget_admission_top dut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_origin_x(req_origin_x),
      .req_origin_y(req_origin_y),
      .req_object_width(req_object_width),
      .req_object_height(req_object_height),
      .req_object_tiles(req_object_tiles),
      .req_shot_y(req_shot_y),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_admitted(rsp_admitted),
      .rsp_slots_used(rsp_slots_used)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("sprite_row_budget_admission_top test failed");
      $finish;
   end

   // Once armed, the receiver refuses responses for a long stretch so that the
   // block fills up and has to stall the request side.
   always @(posedge clock) begin
      if (hold_armed && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_admitted, rsp_slots_used);
   end

   function automatic request_type random_fields();
      request_type r;
      r.command       = 2'($urandom_range(3));
      r.pos_x         = 16'($urandom);
      r.pos_y         = 16'($urandom);
      r.origin_x      = 8'($urandom);
      r.origin_y      = 8'($urandom);
      r.object_width  = 8'($urandom);
      r.object_height = 8'($urandom);
      r.object_tiles  = 6'($urandom);
      r.shot_y        = 8'($urandom);
      return r;
   endfunction

   function automatic request_type cmd_req(logic [1:0] command);
      request_type r;
      r = random_fields();
      r.command = command;
      return r;
   endfunction

   function automatic request_type object_req(int px, int py, int ox, int oy, int w, int h,
                                              int tiles);
      request_type r;
      r = cmd_req(srba_pkg::CMD_OBJECT);
      r.pos_x = px[15:0];
      r.pos_y = py[15:0];
      r.origin_x = ox[7:0];
      r.origin_y = oy[7:0];
      r.object_width = w[7:0];
      r.object_height = h[7:0];
      r.object_tiles = tiles[5:0];
      return r;
   endfunction

   function automatic request_type shot_req(int y);
      request_type r;
      r = cmd_req(srba_pkg::CMD_SHOT);
      r.shot_y = y[7:0];
      return r;
   endfunction

   // Objects are mostly placed around the visible screen with small sizes, so
   // that frames fill up; a share of fully random transactions is mixed in.
   function automatic request_type random_request();
      request_type r;
      int sel, px, py, frac;
      r = random_fields();
      sel = $urandom_range(99);
      if (sel < 15) return r;
      if (sel < 19) begin
         r.command = srba_pkg::CMD_CLEAR;
      end else if (sel < 62) begin
         r.command = srba_pkg::CMD_OBJECT;
         px = int'($urandom_range(215)) - 40 + int'(r.origin_x);
         py = int'($urandom_range(190)) - 40 + int'(r.origin_y);
         frac = $urandom_range(15);
         r.pos_x = (px >= 0) ? 16'(px * 16 + frac) : 16'(px * 16 - frac);
         frac = $urandom_range(15);
         r.pos_y = (py >= 0) ? 16'(py * 16 + frac) : 16'(py * 16 - frac);
         if ($urandom_range(9) != 0) r.object_width = 8'($urandom_range(40));
         if ($urandom_range(9) != 0) r.object_height = 8'($urandom_range(48));
         if ($urandom_range(9) != 0) r.object_tiles = 6'($urandom_range(6));
      end else begin
         r.command = srba_pkg::CMD_SHOT;
         if ($urandom_range(9) != 0) r.shot_y = 8'($urandom_range(1, 160));
      end
      return r;
   endfunction

   task automatic send(input request_type r);
      int gap;
      if ($urandom_range(99) < req_idle_pct) begin
         gap = ($urandom_range(7) == 0) ? $urandom_range(4, 45) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_command       <= r.command;
      req_pos_x         <= r.pos_x;
      req_pos_y         <= r.pos_y;
      req_origin_x      <= r.origin_x;
      req_origin_y      <= r.origin_y;
      req_object_width  <= r.object_width;
      req_object_height <= r.object_height;
      req_object_tiles  <= r.object_tiles;
      req_shot_y        <= r.shot_y;
      req_valid         <= 1'b1;
      do @(posedge clock); while (!req_ready);
      board.note_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
   endtask

   // The enable is left high; the caller lowers it after its last write.
   task automatic csr_write(input logic [srba_pkg::CSR_INDEX_W-1:0] index,
                            input logic [srba_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      board.set_register(index, data);
   endtask

   initial begin
      logic [srba_pkg::CSR_DATA_W-1:0] row_set [PHASES];
      logic [srba_pkg::CSR_DATA_W-1:0] slot_set [PHASES];
      row_set = '{6'd10, 6'd15, 6'd1, 6'd4, 6'd7, 6'd2};
      slot_set = '{6'd40, 6'd63, 6'd1, 6'd12, 6'd25, 6'd63};
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send(cmd_req(srba_pkg::CMD_CLEAR));
      send(cmd_req(srba_pkg::CMD_NONE));
      send(object_req(0, 0, 0, 0, 16, 16, 2));
      // A position of -15/16 pixel truncates towards zero, onto the screen edge.
      send(object_req(-15, -15, 0, 0, 8, 1, 1));
      send(object_req(-32768, -32768, 0, 0, 255, 255, 63));
      send(object_req(32767, 32767, 255, 255, 8, 16, 1));
      // Tallest object rounds up to 256 rows and is clipped at both ends.
      send(object_req(50 * 16, -100 * 16, 0, 0, 7, 255, 0));
      send(object_req(40 * 16, 140 * 16, 0, 0, 16, 16, 1));
      send(object_req(10 * 16, 0, 0, 0, 255, 16, 1));
      send(object_req(10 * 16, 50 * 16, 0, 0, 8, 16, 63));
      send(object_req(-8 * 16, 0, 0, 0, 8, 16, 1));
      send(object_req(160 * 16, 0, 0, 0, 8, 16, 1));
      send(shot_req(0));
      send(shot_req(1));
      send(shot_req(8));
      send(shot_req(16));
      send(shot_req(151));
      send(shot_req(160));
      send(shot_req(255));
      drain();

      // Limits lowered in the middle of a frame, plus writes to spare indexes.
      csr_write(srba_pkg::CSR_ROW_LIMIT, 6'h3F);
      csr_write(CSR_SPARE_A, 6'h2A);
      csr_write(CSR_SPARE_B, 6'h15);
      csr_write(srba_pkg::CSR_ROW_LIMIT, 6'd1);
      csr_write(srba_pkg::CSR_SLOT_LIMIT, 6'd2);
      csr_write_en <= 1'b0;
      send(shot_req(100));
      drain();

      csr_write(srba_pkg::CSR_ROW_LIMIT, 6'd0);
      csr_write(srba_pkg::CSR_SLOT_LIMIT, 6'd0);
      csr_write_en <= 1'b0;
      send(cmd_req(srba_pkg::CMD_CLEAR));
      send(shot_req(50));
      send(object_req(30 * 16, 30 * 16, 0, 0, 7, 16, 0));
      send(object_req(30 * 16, 30 * 16, 0, 0, 8, 16, 0));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         req_idle_pct = (p < 2) ? 13 : (p < 4) ? 55 : 0;
         rsp_idle_pct = (p < 2) ? 55 : (p < 4) ? 13 : 0;
         csr_write(srba_pkg::CSR_ROW_LIMIT, row_set[p]);
         csr_write(srba_pkg::CSR_SLOT_LIMIT, slot_set[p]);
         csr_write_en <= 1'b0;
         if (p == 4) hold_armed = 1'b1;
         repeat (ITEMS_PER_PHASE) send(random_request());
         drain();
      end

      repeat (60) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("sprite_row_budget_admission_top test passed");
      else
         $display("sprite_row_budget_admission_top test failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/srba_pkg.sv
hdl/sprite_row_budget_admission_top.sv
tb/sprite_row_budget_admission_top_test.sv
